>>> src/message_channel_ring_fifo_core_macros.svh
// assertion macros for the message channel ring fifo
`ifndef MESSAGE_CHANNEL_RING_FIFO_CORE_MACROS_SVH
`define MESSAGE_CHANNEL_RING_FIFO_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define MCRF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MCRF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mcrf_pkg.sv
// shared types and constants for the message channel ring fifo
package mcrf_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int ACTION_W = 3;
    localparam int CFG_W    = 3;
    localparam int PHASE_W  = 2;

    localparam logic [CFG_W-1:0] CAP_LOG2_RESET = 3'd6;

    localparam logic [ACTION_W-1:0] ACT_SEND      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_RECV      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_TX_SEND   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_TX_RECV   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TX_END    = 3'd4;

    localparam logic [PHASE_W-1:0] PHASE_ACK     = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_ONGOING = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_ENDED   = 2'd2;

    typedef struct packed {
        logic               accepted;
        logic               popped;
        logic               done;
        logic               is_full;
        logic               is_empty;
        logic [PHASE_W-1:0] link_state;
    } status_t;

endpackage

>>> src/message_channel_ring_fifo_core.sv
// top level of the message channel ring fifo
//
//  channel   dir   handshake            contents
//  s_*       in    s_valid / s_ready    action, send word, last-in-batch flag
//  m_*       out   m_valid / m_ready    status, received word, occupancy, link state
//  cfg_*     in    cfg_valid / cfg_ready  capacity log2 (restarts the channel)
//
// one word per cycle while m_ready stays high; the result shows the cycle after
// acceptance, when the ring's registered read port returns the popped word.
// s_ready drops only in reset or while a result waits and m_ready is low.
// reset is synchronous; the ring needs no clearing pass, counters start at zero.
// a cfg write zeroes head, tail and the link phase.
`include "message_channel_ring_fifo_core_macros.svh"

module message_channel_ring_fifo_core #(
    parameter int DEPTH      = mcrf_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = mcrf_pkg::DATA_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mcrf_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mcrf_pkg::ACTION_W-1:0]     s_action,
    input  logic signed [DATA_WIDTH-1:0]      s_send_data,
    input  logic                              s_last_in_batch,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_accepted,
    output logic signed [DATA_WIDTH-1:0]      m_recv_data,
    output logic                              m_transmission_done,
    output logic [$clog2(DEPTH+1)-1:0]        m_occupancy,
    output logic                              m_is_full,
    output logic                              m_is_empty,
    output logic [mcrf_pkg::PHASE_W-1:0]      m_link_state
);
    import mcrf_pkg::*;

    localparam int CAP_LOG2_MAX = $clog2(DEPTH + 1) - 1;
    localparam int ADDR_W       = CAP_LOG2_MAX;

    logic                  m_valid_reg, m_valid_next;
    logic                  item_we;
    status_t               status;
    logic                  mem_wr_en;
    logic [ADDR_W-1:0]     mem_wr_addr;
    logic                  mem_rd_en;
    logic [ADDR_W-1:0]     mem_rd_addr;
    logic [DATA_WIDTH-1:0] mem_rd_data;

    assign cfg_ready = aresetn;
    assign s_ready   = aresetn && (!m_valid_reg || m_ready);
    assign item_we   = s_valid && s_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (item_we) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    mcrf_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_valid),
        .cfg_data      (cfg_data),
        .item_we       (item_we),
        .action        (s_action),
        .last_in_batch (s_last_in_batch),
        .status        (status),
        .occupancy     (m_occupancy),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr)
    );

    mcrf_ring_mem #(
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (s_send_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign m_valid             = m_valid_reg;
    assign m_accepted          = status.accepted;
    assign m_recv_data         = status.popped ? mem_rd_data : '0;
    assign m_transmission_done = status.done;
    assign m_is_full           = status.is_full;
    assign m_is_empty          = status.is_empty;
    assign m_link_state        = status.link_state;

    `MCRF_ASSERT_NEXT(a_item_gives_result, aclk, aresetn, item_we, m_valid, "accepted word gave no result")
    `MCRF_ASSERT_NOW(a_done_means_drained, aclk, aresetn, m_valid && m_transmission_done, m_is_empty && m_link_state == PHASE_ACK, "done without drained acknowledged link")
    `MCRF_ASSERT_NOW(a_refused_reads_zero, aclk, aresetn, m_valid && !m_accepted, m_recv_data == '0, "refused word carries data")

endmodule

>>> src/mcrf_ring_mem.sv
// ring storage: one write port, one registered read port
module mcrf_ring_mem #(
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_W     = 6
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [2**ADDR_W];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/mcrf_ctrl.sv
// head/tail counters, link phase, capacity register and result status
module mcrf_ctrl #(
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [mcrf_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  item_we,
    input  logic [mcrf_pkg::ACTION_W-1:0]         action,
    input  logic                                  last_in_batch,
    output mcrf_pkg::status_t                     status,
    output logic [$clog2(DEPTH+1)-1:0]            occupancy,
    output logic                                  mem_wr_en,
    output logic [$clog2(DEPTH+1)-2:0]            mem_wr_addr,
    output logic                                  mem_rd_en,
    output logic [$clog2(DEPTH+1)-2:0]            mem_rd_addr
);
    import mcrf_pkg::*;

    localparam int CAP_LOG2_MAX = $clog2(DEPTH + 1) - 1;
    localparam int CNT_W        = CAP_LOG2_MAX + 1;
    localparam int ADDR_W       = CAP_LOG2_MAX;
    localparam int LG_W         = $clog2(CAP_LOG2_MAX + 1);

    logic [CFG_W-1:0]   cap_log2_reg;
    logic [CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]   wr_cnt_reg, wr_cnt_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    status_t            status_reg, status_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;

    logic [LG_W-1:0]    cap_lg;
    logic [CNT_W-1:0]   cap;
    logic [CNT_W-1:0]   cap_mask;
    logic [CNT_W-1:0]   occ_now;
    logic               full_now;
    logic               empty_now;
    logic               do_push;
    logic               do_pop;
    logic               done;
    logic [CNT_W-1:0]   wr_slot;
    logic [CNT_W-1:0]   rd_slot;

    // clamp the programmed size into two..largest power of two in the ring
    always_comb begin
        if (cap_log2_reg == '0) begin
            cap_lg = LG_W'(1);
        end else if (32'(cap_log2_reg) > CAP_LOG2_MAX) begin
            cap_lg = LG_W'(CAP_LOG2_MAX);
        end else begin
            cap_lg = LG_W'(cap_log2_reg);
        end
    end

    assign cap       = CNT_W'(1) << cap_lg;
    assign cap_mask  = cap - CNT_W'(1);
    assign occ_now   = wr_cnt_reg - rd_cnt_reg;
    assign full_now  = (occ_now == cap);
    assign empty_now = (occ_now == '0);

    always_comb begin
        do_push    = 1'b0;
        do_pop     = 1'b0;
        done       = 1'b0;
        phase_next = phase_reg;
        unique case (action)
            ACT_SEND: begin
                do_push = !full_now;
            end
            ACT_RECV: begin
                do_pop = !empty_now;
            end
            ACT_TX_SEND: begin
                if (phase_reg != PHASE_ENDED) begin
                    do_push = !full_now;
                    if (phase_reg == PHASE_ACK) begin
                        phase_next = PHASE_ONGOING;
                    end
                end
            end
            ACT_TX_RECV: begin
                if (phase_reg != PHASE_ACK) begin
                    do_pop = !empty_now;
                    // drained after this pop: ring held at most the one word
                    if (last_in_batch && phase_reg == PHASE_ENDED &&
                        occ_now <= CNT_W'(1)) begin
                        phase_next = PHASE_ACK;
                        done       = 1'b1;
                    end
                end
            end
            ACT_TX_END: begin
                phase_next = PHASE_ENDED;
            end
            default: begin
            end
        endcase
    end

    assign wr_cnt_next = wr_cnt_reg + CNT_W'(do_push);
    assign rd_cnt_next = rd_cnt_reg + CNT_W'(do_pop);
    assign occ_next    = wr_cnt_next - rd_cnt_next;

    always_comb begin
        status_next.accepted   = do_push | do_pop;
        status_next.popped     = do_pop;
        status_next.done       = done;
        status_next.is_full    = (occ_next == cap);
        status_next.is_empty   = (occ_next == '0);
        status_next.link_state = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_log2_reg <= CAP_LOG2_RESET;
            rd_cnt_reg   <= '0;
            wr_cnt_reg   <= '0;
            phase_reg    <= PHASE_ACK;
        end else if (cfg_we) begin
            cap_log2_reg <= cfg_data;
            rd_cnt_reg   <= '0;
            wr_cnt_reg   <= '0;
            phase_reg    <= PHASE_ACK;
        end else if (item_we) begin
            rd_cnt_reg   <= rd_cnt_next;
            wr_cnt_reg   <= wr_cnt_next;
            phase_reg    <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_we) begin
            status_reg <= status_next;
            occ_reg    <= occ_next;
        end
    end

    assign wr_slot     = wr_cnt_reg & cap_mask;
    assign rd_slot     = rd_cnt_reg & cap_mask;
    assign mem_wr_en   = item_we & do_push;
    assign mem_wr_addr = wr_slot[ADDR_W-1:0];
    assign mem_rd_en   = item_we & do_pop;
    assign mem_rd_addr = rd_slot[ADDR_W-1:0];

    assign status    = status_reg;
    assign occupancy = occ_reg;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the message channel ring fifo core
module tb;
    import mcrf_pkg::*;

    localparam int DW             = DATA_WIDTH_DEF;
    localparam int RING_DEPTH     = DEPTH_DEF;
    localparam int OCC_W          = $clog2(RING_DEPTH + 1);
    localparam int IDX_W          = $clog2(RING_DEPTH);
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;
    localparam int TARGET_WORDS   = 1950;
    localparam int HOLD_CYCLES    = 300;

    localparam logic [ACTION_W-1:0] ACT_RSVD_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RSVD_LAST  = 3'd7;

    localparam logic [CFG_W-1:0] CAP_LOG2_MIN = 3'd1;
    localparam logic [CFG_W-1:0] CAP_LOG2_MAX = 3'd6;
    localparam logic [CFG_W-1:0] CFG_RAW_ZERO = 3'd0;
    localparam logic [CFG_W-1:0] CFG_RAW_TOP  = 3'd7;

    typedef struct packed {
        logic               accepted;
        logic [DW-1:0]      recv_data;
        logic               done;
        logic [OCC_W-1:0]   occupancy;
        logic               is_full;
        logic               is_empty;
        logic [PHASE_W-1:0] link_state;
    } word_status_t;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_W-1:0]          cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic [ACTION_W-1:0]       s_action;
    logic signed [DW-1:0]      s_send_data;
    logic                      s_last_in_batch;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_accepted;
    logic signed [DW-1:0]      m_recv_data;
    logic                      m_transmission_done;
    logic [OCC_W-1:0]          m_occupancy;
    logic                      m_is_full;
    logic                      m_is_empty;
    logic [PHASE_W-1:0]        m_link_state;

    message_channel_ring_fifo_core #(
        .DEPTH      (RING_DEPTH),
        .DATA_WIDTH (DW)
    ) uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_send_data         (s_send_data),
        .s_last_in_batch     (s_last_in_batch),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_accepted          (m_accepted),
        .m_recv_data         (m_recv_data),
        .m_transmission_done (m_transmission_done),
        .m_occupancy         (m_occupancy),
        .m_is_full           (m_is_full),
        .m_is_empty          (m_is_empty),
        .m_link_state        (m_link_state)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // channel mirror
    logic [DW-1:0]      ring_mirror [RING_DEPTH];
    int unsigned        head_cnt;
    int unsigned        tail_cnt;
    logic [PHASE_W-1:0] link_mirror;
    logic [CFG_W-1:0]   cap_log2_mirror;

    word_status_t pending_status [$];

    int unsigned words_sent;
    int unsigned results_checked;
    int unsigned mismatches;
    int unsigned stray_results;
    int unsigned drains_seen;
    int unsigned full_seen;
    int unsigned cfg_writes;
    int unsigned burst_left;
    bit          sender_gaps;
    int unsigned rx_mode;
    int unsigned rx_hold_cycles;

    function automatic int unsigned ring_capacity();
        int unsigned lg;
        int unsigned cap;
        int unsigned k;
        lg  = (cap_log2_mirror < 1) ? 1 : cap_log2_mirror;
        cap = 2;
        for (k = 1; k < lg && cap * 2 <= RING_DEPTH; k++)
            cap *= 2;
        return cap;
    endfunction

    function automatic bit push_mirror(input logic [DW-1:0] w);
        int unsigned cap;
        cap = ring_capacity();
        if (tail_cnt - head_cnt >= cap)
            return 1'b0;
        ring_mirror[IDX_W'(tail_cnt & (cap - 1))] = w;
        tail_cnt++;
        return 1'b1;
    endfunction

    function automatic bit pop_mirror(output logic [DW-1:0] w);
        int unsigned cap;
        cap = ring_capacity();
        w   = '0;
        if (tail_cnt == head_cnt)
            return 1'b0;
        w = ring_mirror[IDX_W'(head_cnt & (cap - 1))];
        head_cnt++;
        return 1'b1;
    endfunction

    function automatic word_status_t predict_channel(input logic [ACTION_W-1:0] act,
                                                     input logic [DW-1:0] data,
                                                     input logic last);
        word_status_t st;
        logic [DW-1:0] got;
        bit            acc;
        bit            done;
        int unsigned   occ;
        got  = '0;
        acc  = 1'b0;
        done = 1'b0;
        case (act)
            ACT_SEND: acc = push_mirror(data);
            ACT_RECV: acc = pop_mirror(got);
            ACT_TX_SEND: begin
                if (link_mirror != PHASE_ENDED) begin
                    if (link_mirror == PHASE_ACK)
                        link_mirror = PHASE_ONGOING;
                    acc = push_mirror(data);
                end
            end
            ACT_TX_RECV: begin
                if (link_mirror != PHASE_ACK) begin
                    acc = pop_mirror(got);
                    // drain check also fires when the ring was already empty
                    if (last && link_mirror == PHASE_ENDED && tail_cnt == head_cnt) begin
                        link_mirror = PHASE_ACK;
                        done        = 1'b1;
                    end
                end
            end
            ACT_TX_END: link_mirror = PHASE_ENDED;
            default: ;
        endcase
        occ           = tail_cnt - head_cnt;
        st.accepted   = acc;
        st.recv_data  = acc ? got : '0;
        st.done       = done;
        st.occupancy  = occ[OCC_W-1:0];
        st.is_full    = (occ == ring_capacity());
        st.is_empty   = (occ == 0);
        st.link_state = link_mirror;
        if (done)
            drains_seen++;
        if (st.is_full)
            full_seen++;
        return st;
    endfunction

    // receiver: long hold-off when requested, otherwise a per-phase pattern
    always @(negedge aclk) begin : rx_pattern
        int unsigned tick;
        tick++;
        if (rx_hold_cycles > 0) begin
            m_ready <= 1'b0;
            rx_hold_cycles--;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 1) != 0);
                default: m_ready <= ((tick % 7) < 4);
            endcase
        end
    end

    always @(posedge aclk) begin : result_check
        word_status_t got;
        word_status_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_accepted, m_recv_data, m_transmission_done, m_occupancy,
                   m_is_full, m_is_empty, m_link_state};
            results_checked++;
            if (pending_status.size() == 0) begin
                stray_results++;
                if (stray_results + mismatches <= MAX_REPORTS)
                    $display("%0t: result word with nothing outstanding: %p", $realtime, got);
            end else begin
                want = pending_status.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (stray_results + mismatches <= MAX_REPORTS) begin
                        $display("%0t: mismatch acc/data/done/occ/full/empty/link", $realtime);
                        $display("  exp %b %h %b %0d %b %b %0d", want.accepted, want.recv_data,
                                 want.done, want.occupancy, want.is_full, want.is_empty,
                                 want.link_state);
                        $display("  got %b %h %b %0d %b %b %0d", got.accepted, got.recv_data,
                                 got.done, got.occupancy, got.is_full, got.is_empty,
                                 got.link_state);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        int unsigned idle_cycles;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [DW-1:0] data,
                             input logic last);
        if (sender_gaps && burst_left == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_action        <= act;
        s_send_data     <= data;
        s_last_in_batch <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_status.push_back(predict_channel(act, data, last));
        words_sent++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // only written once every outstanding result has come back
    task automatic write_capacity(input logic [CFG_W-1:0] value);
        stop_sending();
        while (pending_status.size() != 0) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cap_log2_mirror = value;
        head_cnt        = 0;
        tail_cnt        = 0;
        link_mirror     = PHASE_ACK;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_basic_actions();
        int code;
        sender_gaps = 1'b0;
        rx_mode     = 0;
        send_word(ACT_RECV, $urandom(), 1'b0);       // empty ring
        send_word(ACT_TX_RECV, $urandom(), 1'b1);    // refused while acknowledged
        send_word(ACT_SEND, 32'h7fff_ffff, 1'b0);
        send_word(ACT_SEND, 32'h8000_0000, 1'b1);
        send_word(ACT_SEND, '0, 1'b0);
        send_word(ACT_SEND, '1, 1'b1);
        send_word(ACT_RECV, $urandom(), 1'b0);
        send_word(ACT_RECV, $urandom(), 1'b1);
        send_word(ACT_TX_SEND, $urandom(), 1'b1);
        for (code = ACT_RSVD_FIRST; code <= ACT_RSVD_LAST; code++)
            send_word(code[ACTION_W-1:0], $urandom(), code[0]);
        send_word(ACT_TX_END, $urandom(), 1'b0);
        send_word(ACT_TX_SEND, $urandom(), 1'b0);    // refused once ended
        send_word(ACT_TX_RECV, $urandom(), 1'b0);
        send_word(ACT_TX_RECV, $urandom(), 1'b1);
        send_word(ACT_TX_RECV, $urandom(), 1'b1);    // drains, back to acknowledged
        send_word(ACT_TX_RECV, $urandom(), 1'b1);
        stop_sending();
    endtask

    task automatic test_capacity_limits();
        int unsigned i;
        rx_mode = 1;
        write_capacity(CAP_LOG2_MIN);
        repeat (3) send_word(ACT_SEND, $urandom(), 1'b0);
        send_word(ACT_TX_SEND, $urandom(), 1'b0);    // full, but link still opens
        send_word(ACT_TX_END, $urandom(), 1'b0);
        send_word(ACT_TX_RECV, $urandom(), 1'b1);
        send_word(ACT_TX_RECV, $urandom(), 1'b1);
        send_word(ACT_TX_END, $urandom(), 1'b1);
        send_word(ACT_TX_RECV, $urandom(), 1'b1);    // already empty
        for (i = 0; i < 5; i++) begin
            send_word(ACT_SEND, $urandom(), 1'b0);
            send_word(ACT_RECV, $urandom(), 1'b0);
        end
        write_capacity(CFG_RAW_ZERO);
        repeat (3) send_word(ACT_SEND, $urandom(), 1'b0);
        send_word(ACT_RECV, $urandom(), 1'b0);
        write_capacity(CFG_RAW_TOP);
        for (i = 0; i <= RING_DEPTH; i++)
            send_word(ACT_TX_SEND, $urandom(), 1'b0);
        send_word(ACT_TX_END, $urandom(), 1'b0);
        for (i = 0; i <= RING_DEPTH; i++)
            send_word(ACT_TX_RECV, $urandom(), i == RING_DEPTH);
        // restart with words held and the link ended
        repeat (3) send_word(ACT_SEND, $urandom(), 1'b0);
        send_word(ACT_TX_END, $urandom(), 1'b0);
        write_capacity(CAP_LOG2_MAX);
        send_word(ACT_RECV, $urandom(), 1'b0);
        send_word(ACT_TX_RECV, $urandom(), 1'b1);
        stop_sending();
    endtask

    task automatic test_backpressure();
        int unsigned i;
        sender_gaps    = 1'b0;
        rx_mode        = 0;
        rx_hold_cycles = HOLD_CYCLES;
        for (i = 0; i < 48; i++)
            send_word($urandom_range(0, 1) ? ACT_SEND : ACT_RECV, $urandom(), 1'b0);
        stop_sending();
    endtask

    task automatic run_sequence();
        int unsigned kind;
        int unsigned n;
        int unsigned cap;
        int unsigned i;
        bit          close_link;
        cap  = ring_capacity();
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            n          = $urandom_range(1, cap + 2);
            close_link = ($urandom_range(0, 4) != 0);
            for (i = 0; i < n; i++)
                send_word(ACT_TX_SEND, $urandom(), 1'($urandom_range(0, 1)));
            if (close_link)
                send_word(ACT_TX_END, $urandom(), 1'($urandom_range(0, 1)));
            n = n + $urandom_range(0, 1);
            for (i = 0; i < n; i++)
                send_word(ACT_TX_RECV, $urandom(), (i == n - 1) || ($urandom_range(0, 5) == 0));
        end else if (kind < 8) begin
            n = $urandom_range(1, cap + 1);
            for (i = 0; i < n; i++)
                send_word(ACT_SEND, $urandom(), 1'($urandom_range(0, 1)));
            n = $urandom_range(1, cap + 1);
            for (i = 0; i < n; i++)
                send_word(ACT_RECV, $urandom(), 1'($urandom_range(0, 1)));
        end else begin
            n = $urandom_range(4, 16);
            for (i = 0; i < n; i++)
                send_word(ACTION_W'($urandom_range(0, 7)), $urandom(),
                          1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random_traffic();
        int unsigned      phase;
        int unsigned      phase_start;
        logic [CFG_W-1:0] cfg;
        phase = 0;
        while (words_sent < TARGET_WORDS) begin
            // sweep every legal size first, then any register value
            cfg = (phase < 6) ? CAP_LOG2_MIN + phase[CFG_W-1:0] : CFG_W'($urandom_range(0, 7));
            write_capacity(cfg);
            rx_mode     = $urandom_range(0, 3);
            sender_gaps = ($urandom_range(0, 3) != 0);
            phase_start = words_sent;
            while (words_sent - phase_start < 150 && words_sent < TARGET_WORDS)
                run_sequence();
            phase++;
        end
        stop_sending();
    endtask

    initial begin
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_action        = ACT_SEND;
        s_send_data     = '0;
        s_last_in_batch = 1'b0;
        m_ready         = 1'b0;
        rx_mode         = 0;
        rx_hold_cycles  = 0;
        sender_gaps     = 1'b0;
        burst_left      = 0;
        head_cnt        = 0;
        tail_cnt        = 0;
        link_mirror     = PHASE_ACK;
        cap_log2_mirror = CAP_LOG2_RESET;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_basic_actions();
        test_capacity_limits();
        test_backpressure();
        test_random_traffic();

        while (pending_status.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("%0d words sent under %0d capacity writes, %0d result words checked",
                 words_sent, cfg_writes, results_checked);
        $display("%0d transmissions drained to done, %0d results with the ring full",
                 drains_seen, full_seen);
        if (mismatches == 0 && stray_results == 0 && pending_status.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
